/* rtl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared types, header offsets, byte constants and status codes for the
// 8-bit PCX run-length decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	// default largest accepted width or height
	localparam int MAX_DIM_DEF = 4096;

	// header byte constants
	localparam logic [7:0]  HDR_SIG      = 8'h0A;
	localparam logic [7:0]  HDR_VERSION  = 8'h05;
	localparam logic [7:0]  HDR_ENC_RLE  = 8'h01;
	localparam logic [7:0]  HDR_BPP      = 8'h08;
	localparam logic [7:0]  HDR_PLANES   = 8'h01;
	localparam logic [15:0] HDR_PAL_INFO = 16'h0001;

	// run header: top two bits set, low six bits are the count
	localparam logic [7:0] RUN_MARK = 8'hC0;

	// footer signature ahead of the palette
	localparam logic [7:0] FOOT_SIG = 8'h0C;

	// header byte offsets
	localparam logic [6:0] OFS_SIG       = 7'd0;
	localparam logic [6:0] OFS_VER       = 7'd1;
	localparam logic [6:0] OFS_ENC       = 7'd2;
	localparam logic [6:0] OFS_BPP       = 7'd3;
	localparam logic [6:0] OFS_WIN       = 7'd4;
	localparam logic [6:0] OFS_WIN_END   = 7'd11;
	localparam logic [6:0] OFS_PLANES    = 7'd65;
	localparam logic [6:0] OFS_STRIDE_LO = 7'd66;
	localparam logic [6:0] OFS_STRIDE_HI = 7'd67;
	localparam logic [6:0] OFS_PAL_LO    = 7'd68;
	localparam logic [6:0] OFS_PAL_HI    = 7'd69;
	localparam logic [6:0] OFS_LAST      = 7'd127;

	// footer: signature plus 768 palette bytes; position of the last byte
	localparam logic [9:0] FOOT_LAST = 10'd768;

	// status codes
	localparam logic [3:0] CODE_OK          = 4'd0;
	localparam logic [3:0] CODE_TRUNCATED   = 4'd1;
	localparam logic [3:0] CODE_SHORT_HDR   = 4'd2;
	localparam logic [3:0] CODE_SIGNATURE   = 4'd3;
	localparam logic [3:0] CODE_VERSION     = 4'd4;
	localparam logic [3:0] CODE_ENCODING    = 4'd5;
	localparam logic [3:0] CODE_BPP         = 4'd6;
	localparam logic [3:0] CODE_PLANES      = 4'd7;
	localparam logic [3:0] CODE_PAL_INFO    = 4'd8;
	localparam logic [3:0] CODE_X_ORDER     = 4'd9;
	localparam logic [3:0] CODE_Y_ORDER     = 4'd10;
	localparam logic [3:0] CODE_WIDTH       = 4'd11;
	localparam logic [3:0] CODE_HEIGHT      = 4'd12;
	localparam logic [3:0] CODE_STRIDE      = 4'd13;
	localparam logic [3:0] CODE_SHORT_FOOT  = 4'd14;
	localparam logic [3:0] CODE_BAD_FOOTER  = 4'd15;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_PALETTE = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_CHECK,
		ST_DECIDE,
		ST_DATA,
		ST_EXPAND,
		ST_FOOTER,
		ST_FINAL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OSEL_NONE,
		OSEL_PIXEL,
		OSEL_PALETTE,
		OSEL_STATUS
	} out_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       hdr_capture;
		logic       check_load;
		logic       left_load;
		logic       run_mark;
		logic       run_load;
		logic       pix_step;
		logic       foot_byte;
		out_sel_t   out_sel;
		logic [3:0] stat_code;
		logic       stat_geo;
		logic       stat_empty;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       slot_free;
		logic       hdr_last;
		logic [3:0] pend_code;
		logic [3:0] geo_code;
		logic       total_zero;
		logic       left_one;
		logic       cnt_zero;
		logic       cnt_one;
		logic       run_pending;
		logic       run_hdr;
		logic       foot_start;  // next footer byte is the signature
		logic       foot_last;
		logic       foot_err;
	} dp_sts_t;

endpackage

/* rtl/pcxrle_dp.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Header field capture, geometry check, run counters, footer position and
// the output register.
// ----------------------------------------------------------------------------
module pcxrle_dp #(
	parameter int MAX_DIM = pcxrle_pkg::MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           in_byte,
	input  pcxrle_pkg::dp_cmd_t  cmd,
	output pcxrle_pkg::dp_sts_t  sts,
	input  logic                 result_ready,
	output logic                 result_valid,
	output logic [1:0]           kind,
	output logic [7:0]           value,
	output logic [3:0]           status,
	output logic                 empty_image,
	output logic [12:0]          image_width,
	output logic [12:0]          image_height,
	output logic [15:0]          line_stride,
	output logic                 last
);
	import pcxrle_pkg::*;

	// largest image total is MAX_DIM lines of the widest stride
	localparam longint unsigned MAX_TOTAL = longint'(MAX_DIM) * 65535;
	localparam int              LEFT_W    = $clog2(MAX_TOTAL + 1);

	logic [6:0]        hdr_pos_q;
	logic [3:0][15:0]  win_q;
	logic [15:0]       stride_q;
	logic [7:0]        pal_lo_q;
	logic [3:0]        pend_q;
	logic [3:0]        hdr_err;
	logic [2:0]        widx;

	logic [15:0]       width_c;
	logic [15:0]       height_c;
	logic [3:0]        geo_c;
	logic [15:0]       width_q;
	logic [15:0]       height_q;
	logic [3:0]        geo_q;
	logic [31:0]       total_q;

	logic [LEFT_W-1:0] left_q;
	logic              run_pend_q;
	logic [5:0]        run_cnt_q;
	logic [5:0]        cnt_q;
	logic [7:0]        val_q;

	logic [9:0]        foot_pos_q;
	logic              foot_err_q;

	logic              res_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        value_q;
	logic [3:0]        status_q;
	logic              empty_q;
	logic [12:0]       width_out_q;
	logic [12:0]       height_out_q;
	logic [15:0]       stride_out_q;
	logic              last_q;

	// header byte checks
	assign widx = 3'(hdr_pos_q - OFS_WIN);

	always_comb begin
		hdr_err = CODE_OK;
		case (hdr_pos_q) inside
			OFS_SIG:    if (in_byte != HDR_SIG)     hdr_err = CODE_SIGNATURE;
			OFS_VER:    if (in_byte != HDR_VERSION) hdr_err = CODE_VERSION;
			OFS_ENC:    if (in_byte != HDR_ENC_RLE) hdr_err = CODE_ENCODING;
			OFS_BPP:    if (in_byte != HDR_BPP)     hdr_err = CODE_BPP;
			OFS_PLANES: if (in_byte != HDR_PLANES)  hdr_err = CODE_PLANES;
			OFS_PAL_HI: if ({in_byte, pal_lo_q} != HDR_PAL_INFO) hdr_err = CODE_PAL_INFO;
			default:    hdr_err = CODE_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= '0;
			win_q     <= '0;
			stride_q  <= '0;
			pal_lo_q  <= '0;
			pend_q    <= CODE_OK;
		end else if (cmd.hdr_capture) begin
			hdr_pos_q <= hdr_pos_q + 7'd1;
			if (hdr_err != CODE_OK && pend_q == CODE_OK) begin
				pend_q <= hdr_err;
			end
			case (hdr_pos_q) inside
				[OFS_WIN:OFS_WIN_END]: begin
					if (widx[0]) begin
						win_q[widx[2:1]][15:8] <= in_byte;
					end else begin
						win_q[widx[2:1]][7:0] <= in_byte;
					end
				end
				OFS_STRIDE_LO: stride_q[7:0]  <= in_byte;
				OFS_STRIDE_HI: stride_q[15:8] <= in_byte;
				OFS_PAL_LO:    pal_lo_q       <= in_byte;
				default: ;
			endcase
		end
	end

	// geometry: window words are x_min, y_min, x_max, y_max
	assign width_c  = win_q[2] - win_q[0] + 16'd1;
	assign height_c = win_q[3] - win_q[1] + 16'd1;

	always_comb begin
		if (win_q[0] > win_q[2]) begin
			geo_c = CODE_X_ORDER;
		end else if (win_q[1] > win_q[3]) begin
			geo_c = CODE_Y_ORDER;
		end else if ({1'b0, width_c} > 17'(MAX_DIM)) begin
			geo_c = CODE_WIDTH;
		end else if ({1'b0, height_c} > 17'(MAX_DIM)) begin
			geo_c = CODE_HEIGHT;
		end else if (stride_q < width_c) begin
			geo_c = CODE_STRIDE;
		end else begin
			geo_c = CODE_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_q <= CODE_OK;
		end else if (cmd.check_load) begin
			geo_q <= geo_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check_load) begin
			width_q  <= width_c;
			height_q <= height_c;
			total_q  <= 32'(height_c) * 32'(stride_q);
		end
	end

	// run expansion counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			run_pend_q <= 1'b0;
			run_cnt_q  <= '0;
			cnt_q      <= '0;
		end else begin
			if (cmd.left_load) begin
				left_q <= total_q[LEFT_W-1:0];
			end else if (cmd.pix_step) begin
				left_q <= left_q - LEFT_W'(1);
			end
			if (cmd.run_mark) begin
				run_pend_q <= 1'b1;
				run_cnt_q  <= in_byte[5:0];
			end else if (cmd.run_load) begin
				run_pend_q <= 1'b0;
			end
			if (cmd.run_load) begin
				cnt_q <= run_pend_q ? run_cnt_q : 6'd1;
			end else if (cmd.pix_step) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_load) begin
			val_q <= in_byte;
		end
	end

	// footer position and signature flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foot_pos_q <= '0;
			foot_err_q <= 1'b0;
		end else if (cmd.foot_byte) begin
			foot_pos_q <= foot_pos_q + 10'd1;
			if (foot_pos_q == '0 && in_byte != FOOT_SIG) begin
				foot_err_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_sel != OSEL_NONE) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OSEL_PIXEL, OSEL_PALETTE: begin
				kind_q       <= (cmd.out_sel == OSEL_PIXEL) ? KIND_PIXEL : KIND_PALETTE;
				value_q      <= (cmd.out_sel == OSEL_PIXEL) ? val_q : in_byte;
				status_q     <= CODE_OK;
				empty_q      <= 1'b0;
				width_out_q  <= '0;
				height_out_q <= '0;
				stride_out_q <= '0;
				last_q       <= 1'b0;
			end
			OSEL_STATUS: begin
				kind_q       <= KIND_STATUS;
				value_q      <= '0;
				status_q     <= cmd.stat_code;
				empty_q      <= cmd.stat_empty;
				width_out_q  <= cmd.stat_geo ? width_q[12:0] : 13'd0;
				height_out_q <= cmd.stat_geo ? height_q[12:0] : 13'd0;
				stride_out_q <= cmd.stat_geo ? stride_q : 16'd0;
				last_q       <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign value        = value_q;
	assign status       = status_q;
	assign empty_image  = empty_q;
	assign image_width  = width_out_q;
	assign image_height = height_out_q;
	assign line_stride  = stride_out_q;
	assign last         = last_q;

	always_comb begin
		sts             = '0;
		sts.slot_free   = !res_valid_q || result_ready;
		sts.hdr_last    = hdr_pos_q == OFS_LAST;
		sts.pend_code   = pend_q;
		sts.geo_code    = geo_q;
		sts.total_zero  = total_q == '0;
		sts.left_one    = left_q == LEFT_W'(1);
		sts.cnt_zero    = cnt_q == '0;
		sts.cnt_one     = cnt_q == 6'd1;
		sts.run_pending = run_pend_q;
		sts.run_hdr     = (in_byte & RUN_MARK) == RUN_MARK;
		sts.foot_start  = foot_pos_q == '0;
		sts.foot_last   = foot_pos_q == FOOT_LAST;
		sts.foot_err    = foot_err_q;
	end

endmodule

/* rtl/pcxrle_ctrl.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Phase state machine: header, geometry check, run data, footer, done.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 end_of_stream,
	output logic                 item_ready,
	output pcxrle_pkg::dp_cmd_t  cmd,
	input  pcxrle_pkg::dp_sts_t  sts
);
	import pcxrle_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_comb begin
		case (state_q)
			ST_HEADER, ST_DATA, ST_FOOTER: item_ready = sts.slot_free;
			ST_DONE:                       item_ready = 1'b1;
			default:                       item_ready = 1'b0;
		endcase
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HEADER: begin
				if (accept) begin
					if (end_of_stream) begin
						state_d = ST_DONE;
					end else if (sts.hdr_last) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.pend_code != CODE_OK || sts.geo_code != CODE_OK || sts.total_zero) begin
					if (sts.slot_free) begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (accept) begin
					if (end_of_stream) begin
						state_d = ST_DONE;
					end else if (sts.run_pending || !sts.run_hdr) begin
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				if (sts.cnt_zero) begin
					state_d = ST_DATA;
				end else if (sts.slot_free) begin
					if (sts.left_one) begin
						state_d = ST_FOOTER;
					end else if (sts.cnt_one) begin
						state_d = ST_DATA;
					end
				end
			end
			ST_FOOTER: begin
				if (accept) begin
					if (end_of_stream) begin
						state_d = ST_DONE;
					end else if (sts.foot_last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (sts.slot_free) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_DONE;
			default: state_d = ST_HEADER;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_HEADER: begin
				if (accept) begin
					if (end_of_stream) begin
						cmd.out_sel   = OSEL_STATUS;
						cmd.stat_code = CODE_SHORT_HDR;
					end else begin
						cmd.hdr_capture = 1'b1;
					end
				end
			end
			ST_CHECK: cmd.check_load = 1'b1;
			ST_DECIDE: begin
				if (sts.pend_code != CODE_OK) begin
					if (sts.slot_free) begin
						cmd.out_sel   = OSEL_STATUS;
						cmd.stat_code = sts.pend_code;
					end
				end else if (sts.geo_code != CODE_OK) begin
					if (sts.slot_free) begin
						cmd.out_sel   = OSEL_STATUS;
						cmd.stat_code = sts.geo_code;
					end
				end else if (sts.total_zero) begin
					if (sts.slot_free) begin
						cmd.out_sel    = OSEL_STATUS;
						cmd.stat_code  = CODE_OK;
						cmd.stat_geo   = 1'b1;
						cmd.stat_empty = 1'b1;
					end
				end else begin
					cmd.left_load = 1'b1;
				end
			end
			ST_DATA: begin
				if (accept) begin
					if (end_of_stream) begin
						cmd.out_sel   = OSEL_STATUS;
						cmd.stat_code = CODE_TRUNCATED;
						cmd.stat_geo  = 1'b1;
					end else if (sts.run_pending || !sts.run_hdr) begin
						cmd.run_load = 1'b1;
					end else begin
						cmd.run_mark = 1'b1;
					end
				end
			end
			ST_EXPAND: begin
				if (!sts.cnt_zero && sts.slot_free) begin
					cmd.pix_step = 1'b1;
					cmd.out_sel  = OSEL_PIXEL;
				end
			end
			ST_FOOTER: begin
				if (accept) begin
					if (end_of_stream) begin
						cmd.out_sel   = OSEL_STATUS;
						cmd.stat_code = CODE_SHORT_FOOT;
						cmd.stat_geo  = 1'b1;
					end else begin
						cmd.foot_byte = 1'b1;
						if (!sts.foot_start) begin
							cmd.out_sel = OSEL_PALETTE;
						end
					end
				end
			end
			ST_FINAL: begin
				if (sts.slot_free) begin
					cmd.out_sel   = OSEL_STATUS;
					cmd.stat_code = sts.foot_err ? CODE_BAD_FOOTER : CODE_OK;
					cmd.stat_geo  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// a finished stream stays finished
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("decoder left the done state");

	// nothing is loaded into an occupied output register
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_sel != OSEL_NONE |-> sts.slot_free)
		else $error("result overwritten before it was taken");

	// a pixel is only produced while the run has count left
	a_pix_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_step |-> !sts.cnt_zero && state_q == ST_EXPAND)
		else $error("pixel emitted with an exhausted run");

	// the status item of a finished stream is the last thing emitted
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> cmd.out_sel == OSEL_NONE)
		else $error("result emitted after the stream ended");

endmodule

/* rtl/pcx_rle_image_decoder.sv */
// ----------------------------------------------------------------------------
// PCX 8-bit RLE image decoder
// Checks the 128-byte header, expands run-length pixel data into
// height * stride pixel bytes, passes the 769-byte footer palette and ends
// the stream with one status transaction.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   payload
//   -------   -------------------------   -------------------------------------
//   item      item_valid / item_ready     in_byte, end_of_stream
//   result    result_valid / result_ready kind, value, status, empty_image,
//                                         image_width, image_height,
//                                         line_stride, last
//
// Flow: header and footer bytes are accepted while the result register is
// free. Each data byte is expanded into the pixels of its run (0 to 63 after
// a run header, 1 for a literal) by the single expansion counter, which emits
// one pixel per cycle while the result register is free; a run of zero still
// passes through the expansion state, and a run header byte is only accepted.
// The end of the header passes through the geometry check and the registered
// height * stride product; the closing status follows the last palette byte.
// Reset: arst_n clears the phase, counters and the result valid flag at once;
// no clearing pass is needed.
// Stalls: the result register lets the next byte be accepted while a result
// waits, as long as result_ready takes it in the same cycle.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder #(
	parameter int MAX_DIM = pcxrle_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	// result stream
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [3:0]  status,
	output logic        empty_image,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic [15:0] line_stride,
	output logic        last
);
	import pcxrle_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// phase sequencing: decides which byte means what and when to emit
	pcxrle_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.end_of_stream (end_of_stream),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	// header fields, geometry, run counters, footer position, result register
	pcxrle_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.kind         (kind),
		.value        (value),
		.status       (status),
		.empty_image  (empty_image),
		.image_width  (image_width),
		.image_height (image_height),
		.line_stride  (line_stride),
		.last         (last)
	);

endmodule
